// ----- rtl/core/text_console_writer_macros.svh -----
// Assertion macros used by the console writer top level.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCW_ASSERT_NOW(label, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field widths fixed by the interface.
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;

    // Cell store addressing.
    localparam int ADDR_W = $clog2(CELLS);

    // Command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Character codes and colours.
    localparam logic [CHAR_W-1:0]  NUL_CODE     = 8'h00;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, BLANK_CODE};

    // Commands handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_READ_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [ADDR_W-1:0]  addr;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [POS_W-1:0]  pos;
        logic              scrolled;
        logic [CELL_W-1:0] value;
    } t_result;

    // Status of the back end seen by the front end and the top level.
    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

// ----- rtl/core/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/tcw_front.sv -----
module tcw_front
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [INDEX_W-1:0] i_cell_index,
    input  t_back_status       i_status,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic n_keep;
    logic accept;

    // Decode the input item into a command; null characters and the unused
    // mode are dropped here and never reach the back end.
    always_comb begin
        n_keep     = 1'b1;
        n_cmd.op   = OP_PUT;
        n_cmd.ch   = i_char_code;
        n_cmd.addr = '0;
        case (i_mode)
            MODE_PUT: begin
                if (i_char_code == NUL_CODE) begin
                    n_keep = 1'b0;
                end else if (i_char_code == NEWLINE_CODE) begin
                    n_cmd.op = OP_NEWLINE;
                end
            end
            MODE_CLEAR: begin
                n_cmd.op = OP_CLEAR;
            end
            MODE_READ: begin
                if (i_cell_index < INDEX_W'(CELLS)) begin
                    n_cmd.op   = OP_READ;
                    n_cmd.addr = ADDR_W'(i_cell_index);
                end else begin
                    n_cmd.op = OP_READ_NONE;
                end
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !i_status.init_busy && (!r_valid || i_cmd_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_cmd_ready) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                r_valid <= n_keep;
            end
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- rtl/core/tcw_queue.sv -----
module tcw_queue
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/core/tcw_back.sv -----
module tcw_back
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [COLOR_W-1:0] i_cfg_wr_data,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_result,
    output t_back_status       o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [POS_W-1:0]  LAST_BASE = POS_W'((ROWS - 1) * COLUMNS);

    t_state             r_state;
    logic [COLOR_W-1:0] r_text_color;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [POS_W-1:0]   r_pos;
    logic [ADDR_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic               r_wr_pend;
    logic [CELL_W-1:0]  r_fill_value;
    logic               r_res_due;
    logic               r_res_scroll;
    logic               r_init;
    logic               r_out_valid;
    t_result            r_out;

    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    logic [POS_W-1:0]   n_pos;
    logic               n_scroll;
    logic               wrap;
    logic               pop;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // A command starts only when the result register is free or being freed.
    assign pop = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_ready = pop;

    // Cursor after the popped command.
    always_comb begin
        wrap     = 1'b0;
        n_row    = r_row;
        n_col    = r_col;
        n_pos    = r_pos;
        n_scroll = 1'b0;
        case (i_cmd.op)
            OP_PUT, OP_NEWLINE: begin
                wrap = (i_cmd.op == OP_NEWLINE) || (r_col == COL_W'(COLUMNS - 1));
                if (wrap) begin
                    n_col = '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        n_scroll = 1'b1;
                        n_pos    = LAST_BASE;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_pos = r_pos - POS_W'(r_col) + POS_W'(COLUMNS);
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    n_pos = r_pos + 1'b1;
                end
            end
            OP_CLEAR: begin
                n_row = '0;
                n_col = '0;
                n_pos = '0;
            end
            default: begin
            end
        endcase
    end

    // Cell store port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = r_fill_value;
        ram_re    = 1'b0;
        ram_raddr = r_cnt + ADDR_W'(COLUMNS);
        case (r_state)
            S_IDLE: begin
                if (pop && i_cmd.op == OP_PUT) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(r_pos);
                    ram_wdata = {r_text_color, i_cmd.ch};
                end
                if (pop && i_cmd.op == OP_READ) begin
                    ram_re    = 1'b1;
                    ram_raddr = i_cmd.addr;
                end
            end
            S_SCROLL: begin
                ram_we    = r_wr_pend;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
                ram_re    = (r_cnt != COPY_END);
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_text_color <= RESET_COLOR;
            r_row        <= '0;
            r_col        <= '0;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_wr_pend    <= 1'b0;
            r_fill_value <= RESET_CELL;
            r_res_due    <= 1'b0;
            r_res_scroll <= 1'b0;
            r_init       <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_text_color <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_row        <= n_row;
                        r_col        <= n_col;
                        r_pos        <= n_pos;
                        r_res_scroll <= n_scroll;
                        r_out.row      <= n_row;
                        r_out.col      <= n_col;
                        r_out.pos      <= n_pos;
                        r_out.scrolled <= 1'b0;
                        r_out.value    <= '0;
                        case (i_cmd.op)
                            OP_PUT, OP_NEWLINE: begin
                                if (n_scroll) begin
                                    r_state      <= S_SCROLL;
                                    r_cnt        <= '0;
                                    r_wr_pend    <= 1'b0;
                                    r_res_due    <= 1'b1;
                                    r_fill_value <= {r_text_color, BLANK_CODE};
                                end else begin
                                    r_out_valid <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_state      <= S_FILL;
                                r_cnt        <= '0;
                                r_res_due    <= 1'b1;
                                r_fill_value <= {r_text_color, BLANK_CODE};
                            end
                            OP_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out.value <= ram_rdata;
                    r_state     <= S_IDLE;
                end
                S_SCROLL: begin
                    r_wr_pend <= (r_cnt != COPY_END);
                    r_wr_addr <= r_cnt;
                    if (r_cnt == COPY_END) begin
                        r_state <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FILL: begin
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_IDLE;
                        r_init  <= 1'b0;
                        if (r_res_due) begin
                            r_out_valid    <= 1'b1;
                            r_out.scrolled <= r_res_scroll;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;
    assign o_status.init_busy = r_init;

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------------
// command   | in        | i_in_valid / o_in_ready    | i_mode, i_char_code, i_cell_index
// result    | out       | o_out_valid / i_out_ready  | o_cursor_row, o_cursor_col,
//           |           |                            | o_cursor_pos, o_scrolled, o_cell_value
// colour    | in        | i_cfg_wr_en (no handshake) | i_cfg_wr_data
//
// A character, a newline without scroll or an out-of-range read is finished in the idle
// state and an in-range read passes through S_READ. A scroll copies the rows up, one copy a
// cycle through the store's single ports with the write registered behind the read, then
// fills the bottom row; a clear fills every cell. After reset the store is swept to grey
// blanks and no command is taken.
// The front register and the two-entry queue keep accepting while the back end stalls, until both are full.
`include "text_console_writer_macros.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Colour register.
    input  logic               i_cfg_wr_en,
    input  logic [COLOR_W-1:0] i_cfg_wr_data,
    // Command channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [INDEX_W-1:0] i_cell_index,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ROW_W-1:0]   o_cursor_row,
    output logic [COL_W-1:0]   o_cursor_col,
    output logic [POS_W-1:0]   o_cursor_pos,
    output logic               o_scrolled,
    output logic [CELL_W-1:0]  o_cell_value
);

    // The front end decodes each transfer into a command; the queue decouples it from the
    // back end, which owns the cursor, the colour register and the cell store.
    logic         front_valid;
    t_cmd         front_cmd;
    logic         front_ready;
    logic         queue_valid;
    t_cmd         queue_cmd;
    logic         queue_ready;
    t_result      result;
    t_back_status status;

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .i_status    (status),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    tcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(front_valid),
        .o_push_ready(front_ready),
        .i_push_cmd  (front_cmd),
        .o_pop_valid (queue_valid),
        .i_pop_ready (queue_ready),
        .o_pop_cmd   (queue_cmd)
    );

    // The back end holds each result in its own register until it is taken.
    tcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_cmd_valid  (queue_valid),
        .o_cmd_ready  (queue_ready),
        .i_cmd        (queue_cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result),
        .o_status     (status)
    );

    assign o_cursor_row = result.row;
    assign o_cursor_col = result.col;
    assign o_cursor_pos = result.pos;
    assign o_scrolled   = result.scrolled;
    assign o_cell_value = result.value;

    // The linear position is kept incrementally, so check it against row and column.
    `TCW_ASSERT_NOW(a_pos_matches, o_out_valid,
        o_cursor_pos == POS_W'(o_cursor_row) * POS_W'(COLUMNS) + POS_W'(o_cursor_col),
        "cursor position disagrees with row and column")

    // A scroll always leaves the cursor at the start of the bottom row.
    `TCW_ASSERT_NOW(a_scroll_home, o_out_valid && o_scrolled,
        (o_cursor_row == ROW_W'(ROWS - 1)) && (o_cursor_col == '0),
        "scroll left the cursor off the bottom row start")

    // No command is taken in the first cycle after reset, while the store is being swept.
    `TCW_ASSERT_NOW(a_init_blocks, $past(!i_rst_n), !o_in_ready,
        "command taken during the reset sweep")

    // The reset sweep produces no result.
    `TCW_ASSERT_NEXT(a_init_silent, status.init_busy && !o_out_valid, !o_out_valid,
        "result produced during the reset sweep")

endmodule
